// ===== src/toeq_pkg.sv =====
// Shared types and codes for the time-ordered event queue.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package toeq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int OCC_W        = 7;

	// request modes
	localparam logic [1:0] MODE_PUSH   = 2'd0;
	localparam logic [1:0] MODE_POP    = 2'd1;
	localparam logic [1:0] MODE_FIND   = 2'd2;
	localparam logic [1:0] MODE_REMOVE = 2'd3;

	// response status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// datapath operations
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_LOAD = 3'd1;
	localparam logic [2:0] OP_MIN  = 3'd2;
	localparam logic [2:0] OP_CMP  = 3'd3;
	localparam logic [2:0] OP_FIND = 3'd4;
	localparam logic [2:0] OP_DONE = 3'd5;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] time_key;
		logic [15:0] event_handle;
		logic [31:0] request_id;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [15:0]      out_handle;
		logic [31:0]      out_time;
		logic             last;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	typedef struct packed {
		logic [31:0] s_time;
		logic [15:0] s_handle;
		logic [31:0] s_request;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic [2:0] op;
		logic       rd;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic scan_end;
		logic drop;
		logic out_free;
		logic pop;
	} stat_t;

endpackage

`default_nettype wire

// ===== src/toeq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module toeq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== src/toeq_ctrl.sv =====
// Sequencer for the event queue: dispatches each request and steps the slot scans.
// Depends on toeq_pkg; drives the datapath through cmd_t and reads stat_t.
`default_nettype none

module toeq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic [1:0]      req_mode,
	output logic            req_ready,
	input  toeq_pkg::stat_t stat,
	output toeq_pkg::cmd_t  cmd
);

	import toeq_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MIN_RD = 4'd1;
	localparam logic [3:0] S_MIN_EV = 4'd2;
	localparam logic [3:0] S_CMP_RD = 4'd3;
	localparam logic [3:0] S_CMP_EV = 4'd4;
	localparam logic [3:0] S_FND_RD = 4'd5;
	localparam logic [3:0] S_FND_EV = 4'd6;
	localparam logic [3:0] S_DONE   = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd.op    = OP_NONE;
		cmd.rd    = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op = OP_LOAD;
					case (req_mode)
						MODE_PUSH: state_d = S_DONE;
						MODE_POP:  state_d = stat.empty ? S_DONE : S_MIN_RD;
						MODE_FIND: state_d = stat.empty ? S_DONE : S_FND_RD;
						default:   state_d = stat.empty ? S_DONE : S_CMP_RD;
					endcase
				end
			end
			S_MIN_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_MIN_EV;
			end
			S_MIN_EV: begin
				cmd.op  = OP_MIN;
				state_d = stat.scan_end ? S_CMP_RD : S_MIN_RD;
			end
			S_CMP_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_CMP_EV;
			end
			S_CMP_EV: begin
				// a popped event waits here until the response register frees up
				if (!(stat.drop && stat.pop && !stat.out_free)) begin
					cmd.op = OP_CMP;
					if (stat.scan_end) begin
						state_d = stat.pop ? S_IDLE : S_DONE;
					end else begin
						state_d = S_CMP_RD;
					end
				end
			end
			S_FND_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_FND_EV;
			end
			S_FND_EV: begin
				cmd.op  = OP_FIND;
				state_d = stat.scan_end ? S_DONE : S_FND_RD;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.op  = OP_DONE;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/toeq_dpath.sv =====
// Event queue datapath: slot RAM, fill count, scan pointers, min/best trackers
// and the response register. Depends on toeq_pkg and toeq_ram.
`default_nettype none

module toeq_dpath #(
	parameter int CAPACITY = toeq_pkg::CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  toeq_pkg::cmd_t  cmd,
	input  toeq_pkg::req_t  req,
	output toeq_pkg::stat_t stat,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output toeq_pkg::rsp_t  rsp
);

	import toeq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	req_t          item_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] wp_q;
	logic [CW-1:0] eqn_q;
	logic [CW-1:0] emit_q;
	logic [AW-1:0] idx_q;
	logic [31:0]   min_q;
	logic [31:0]   best_t_q;
	logic [15:0]   best_h_q;
	logic          hit_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	slot_t             rd_slot;
	slot_t             wr_slot;
	logic [SLOT_W-1:0] rd_raw;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;

	logic is_pop;
	logic scan_end;
	logic full;
	logic empty;
	logic drop;
	logic out_free;
	logic emit;
	logic rsp_load;
	logic push_ok;
	logic find_take;
	rsp_t rsp_d;

	toeq_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (CAPACITY)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_slot),
		.rd_en   (cmd.rd),
		.rd_addr (idx_q),
		.rd_data (rd_raw)
	);

	assign rd_slot = slot_t'(rd_raw);

	assign is_pop   = (item_q.mode == MODE_POP);
	assign scan_end = (CW'(idx_q) == cnt_q - CW'(1));
	assign full     = (cnt_q == CW'(CAPACITY));
	assign empty    = (cnt_q == '0);
	assign out_free = !rsp_valid_q || rsp_ready;

	// pop drops every slot at the minimum time; remove drops only the oldest match
	always_comb begin
		case (item_q.mode)
			MODE_POP:    drop = (rd_slot.s_time == min_q);
			MODE_REMOVE: drop = (rd_slot.s_handle == item_q.event_handle) &&
				(rd_slot.s_time == item_q.time_key) && !hit_q;
			default:     drop = 1'b0;
		endcase
	end

	assign find_take = (rd_slot.s_request == item_q.request_id) &&
		(!hit_q || (rd_slot.s_time < best_t_q));

	assign emit     = (cmd.op == OP_CMP) && drop && is_pop;
	assign rsp_load = emit || (cmd.op == OP_DONE);
	assign push_ok  = (cmd.op == OP_DONE) && (item_q.mode == MODE_PUSH) && !full;

	// compaction writes a kept slot down to the write pointer; push appends
	assign wr_en   = ((cmd.op == OP_CMP) && !drop) || push_ok;
	assign wr_addr = (cmd.op == OP_CMP) ? wp_q[AW-1:0] : cnt_q[AW-1:0];
	always_comb begin
		if (cmd.op == OP_CMP) begin
			wr_slot = rd_slot;
		end else begin
			wr_slot.s_time    = item_q.time_key;
			wr_slot.s_handle  = item_q.event_handle;
			wr_slot.s_request = item_q.request_id;
		end
	end

	always_comb begin
		rsp_d.status     = ST_OK;
		rsp_d.out_handle = '0;
		rsp_d.out_time   = '0;
		rsp_d.last       = 1'b1;
		rsp_d.occupancy  = OCC_W'(cnt_q);
		if (emit) begin
			rsp_d.out_handle = rd_slot.s_handle;
			rsp_d.out_time   = rd_slot.s_time;
			rsp_d.last       = (emit_q + CW'(1) == eqn_q);
			rsp_d.occupancy  = OCC_W'(cnt_q - eqn_q);
		end else begin
			case (item_q.mode)
				MODE_PUSH: begin
					rsp_d.status    = full ? ST_FULL : ST_OK;
					rsp_d.occupancy = OCC_W'(full ? cnt_q : cnt_q + CW'(1));
				end
				MODE_POP: begin
					rsp_d.status = ST_MISS;
				end
				MODE_FIND: begin
					if (hit_q) begin
						rsp_d.out_handle = best_h_q;
						rsp_d.out_time   = best_t_q;
					end else begin
						rsp_d.status = ST_MISS;
					end
				end
				MODE_REMOVE: begin
					rsp_d.status = hit_q ? ST_OK : ST_MISS;
				end
				default: begin
					rsp_d.status = ST_MISS;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			wp_q        <= '0;
			emit_q      <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD: begin
					idx_q  <= '0;
					wp_q   <= '0;
					emit_q <= '0;
					hit_q  <= 1'b0;
				end
				OP_MIN: begin
					idx_q <= scan_end ? '0 : idx_q + AW'(1);
				end
				OP_FIND: begin
					idx_q <= scan_end ? '0 : idx_q + AW'(1);
					if (find_take) begin
						hit_q <= 1'b1;
					end
				end
				OP_CMP: begin
					idx_q <= scan_end ? '0 : idx_q + AW'(1);
					if (drop) begin
						hit_q <= 1'b1;
						if (is_pop) begin
							emit_q <= emit_q + CW'(1);
						end
					end else begin
						wp_q <= wp_q + CW'(1);
					end
					if (scan_end) begin
						cnt_q <= drop ? wp_q : wp_q + CW'(1);
					end
				end
				OP_DONE: begin
					if (push_ok) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			item_q <= req;
		end
		if (cmd.op == OP_MIN) begin
			if ((idx_q == '0) || (rd_slot.s_time < min_q)) begin
				min_q <= rd_slot.s_time;
				eqn_q <= CW'(1);
			end else if (rd_slot.s_time == min_q) begin
				eqn_q <= eqn_q + CW'(1);
			end
		end
		if ((cmd.op == OP_FIND) && find_take) begin
			best_t_q <= rd_slot.s_time;
			best_h_q <= rd_slot.s_handle;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign stat.empty    = empty;
	assign stat.full     = full;
	assign stat.scan_end = scan_end;
	assign stat.drop     = drop;
	assign stat.out_free = out_free;
	assign stat.pop      = is_pop;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> out_free)
		else $error("response register overwritten while still held");

	a_wp_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CMP) |-> (wp_q <= CW'(idx_q)))
		else $error("compaction write pointer ahead of read index");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.op == OP_CMP) && scan_end && is_pop) |=>
		(cnt_q == $past(cnt_q - eqn_q)))
		else $error("pop left wrong fill count");

endmodule

`default_nettype wire

// ===== src/time_ordered_event_queue_core.sv =====
// Top level of the time-ordered event queue: controller plus datapath.
// Depends on toeq_pkg, toeq_ctrl, toeq_dpath (which holds toeq_ram).
//
//  channel | role   | handshake            | payload
//  --------+--------+----------------------+------------------------------------
//  req     | input  | req_valid/req_ready  | mode, time_key, event_handle, request_id
//  rsp     | output | rsp_valid/rsp_ready  | status, out_handle, out_time, last, occupancy
//
// Push goes straight to the done state. Find and remove scan each event once; pop scans
// them twice (minimum, then compaction). Stalls on rsp hold a request; empty queue
// requests skip scans. Scans read, then evaluate, each slot of the single-read-port RAM.
// Reset clears the fill count, scan state and rsp_valid; slots need no clearing pass.
// A new request is taken once the previous one has issued its last response.
`default_nettype none

module time_ordered_event_queue_core #(
	parameter int CAPACITY = toeq_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  toeq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output toeq_pkg::rsp_t rsp
);

	import toeq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	toeq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_mode  (req.mode),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	toeq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== dv/tb_time_ordered_event_queue_core.sv =====
// Testbench for time_ordered_event_queue_core: directed and random requests, with a
// shadow copy of the event queue in the bench predicting every response.
// Depends on toeq_pkg and the RTL under src.
`default_nettype none

module tb_time_ordered_event_queue_core;
	import toeq_pkg::*;

	localparam int CAP        = 64;
	localparam int N_RANDOM   = 350;
	// slowest request is a pop over a full queue
	localparam int DRAIN_WAIT = 4 * CAP + 40;

	typedef enum bit [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	typedef struct {
		req_t       payload;
		idle_mode_e phase;
		bit         hold_until_drained;
	} stim_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	time_ordered_event_queue_core #(.CAPACITY(CAP)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	slot_t      shadow_q [CAP];
	int         shadow_fill = 0;
	rsp_t       pending_rsp [$];
	stim_t      req_backlog [$];
	idle_mode_e live_phase = IDLE_NONE;

	int n_total    = 0;
	int n_accepted = 0;
	int n_rsp      = 0;
	int n_err      = 0;
	int n_push     = 0;
	int n_pop      = 0;
	int n_find     = 0;
	int n_remove   = 0;
	int n_full     = 0;
	int peak_fill  = 0;

	function automatic int idle_pct(idle_mode_e ph);
		return (ph == IDLE_BOTH) ? 37 : 49;
	endfunction

	// Updates the shadow queue for one request and queues the responses it yields.
	task automatic apply_to_shadow(input req_t r);
		rsp_t        batch [$];
		rsp_t        one;
		logic [31:0] soonest;
		int          kept;
		int          pick;
		begin
			one        = '0;
			one.status = ST_OK;
			one.last   = 1'b1;
			pick       = -1;
			case (r.mode)
				MODE_PUSH: begin
					n_push++;
					if (shadow_fill >= CAP) begin
						one.status = ST_FULL;
						n_full++;
					end else begin
						shadow_q[shadow_fill].s_time    = r.time_key;
						shadow_q[shadow_fill].s_handle  = r.event_handle;
						shadow_q[shadow_fill].s_request = r.request_id;
						shadow_fill++;
					end
					batch.insert(batch.size(), one);
				end
				MODE_POP: begin
					n_pop++;
					if (shadow_fill == 0) begin
						one.status = ST_MISS;
						batch.insert(batch.size(), one);
					end else begin
						soonest = shadow_q[0].s_time;
						for (int i = 1; i < shadow_fill; i++)
							if (shadow_q[i].s_time < soonest)
								soonest = shadow_q[i].s_time;
						kept     = 0;
						one.last = 1'b0;
						for (int i = 0; i < shadow_fill; i++) begin
							if (shadow_q[i].s_time == soonest) begin
								one.out_handle = shadow_q[i].s_handle;
								one.out_time   = shadow_q[i].s_time;
								batch.insert(batch.size(), one);
							end else begin
								shadow_q[kept] = shadow_q[i];
								kept++;
							end
						end
						shadow_fill = kept;
						one         = batch.pop_back();
						one.last    = 1'b1;
						batch.insert(batch.size(), one);
					end
				end
				MODE_FIND: begin
					n_find++;
					// lowest time wins; among equal times the oldest
					for (int i = 0; i < shadow_fill; i++)
						if (shadow_q[i].s_request == r.request_id &&
						    (pick < 0 || shadow_q[i].s_time < shadow_q[pick].s_time))
							pick = i;
					if (pick >= 0) begin
						one.out_handle = shadow_q[pick].s_handle;
						one.out_time   = shadow_q[pick].s_time;
					end else begin
						one.status = ST_MISS;
					end
					batch.insert(batch.size(), one);
				end
				default: begin
					n_remove++;
					for (int i = 0; i < shadow_fill; i++)
						if (pick < 0 && shadow_q[i].s_handle == r.event_handle &&
						    shadow_q[i].s_time == r.time_key)
							pick = i;
					if (pick >= 0) begin
						for (int i = pick; i + 1 < shadow_fill; i++)
							shadow_q[i] = shadow_q[i + 1];
						shadow_fill--;
					end else begin
						one.status = ST_MISS;
					end
					batch.insert(batch.size(), one);
				end
			endcase
			if (shadow_fill > peak_fill)
				peak_fill = shadow_fill;
			foreach (batch[k]) begin
				one           = batch[k];
				one.occupancy = OCC_W'(shadow_fill);
				pending_rsp.insert(pending_rsp.size(), one);
			end
		end
	endtask

	task automatic queue_req(input logic [1:0] m, input logic [31:0] t, input logic [15:0] h,
	                         input logic [31:0] id, input idle_mode_e ph, input bit hold);
		stim_t s;
		begin
			s.payload.mode         = m;
			s.payload.time_key     = t;
			s.payload.event_handle = h;
			s.payload.request_id   = id;
			s.phase                = ph;
			s.hold_until_drained   = hold;
			req_backlog.insert(req_backlog.size(), s);
		end
	endtask

	// Mostly small times so equal-time groups form; the rest full range or near the ends.
	function automatic logic [31:0] pick_time();
		int r;
		begin
			r = $urandom_range(9);
			if (r < 5)
				return 32'($urandom_range(15));
			else if (r < 8)
				return 32'($urandom);
			else if (r == 8)
				return 32'hFFFF_FFFF - 32'($urandom_range(3));
			else
				return 32'($urandom_range(3));
		end
	endfunction

	always @(posedge clk) begin : driver
		stim_t nxt;
		bit    stall_send;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				apply_to_shadow(req);
				n_accepted++;
			end
			stall_send = 1'b1;
			if (req_backlog.size() != 0) begin
				nxt        = req_backlog[0];
				stall_send = (nxt.hold_until_drained && pending_rsp.size() != 0) ||
				             ((nxt.phase == IDLE_SEND || nxt.phase == IDLE_BOTH) &&
				              $urandom_range(99) < idle_pct(nxt.phase));
			end
			if (req_valid && !req_ready) begin
				// request still waiting, payload held
			end else if (!stall_send) begin
				nxt = req_backlog.pop_front();
				req        <= nxt.payload;
				req_valid  <= 1'b1;
				live_phase <= nxt.phase;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				n_rsp++;
				if (pending_rsp.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("unexpected response: st %0d hnd %h time %h last %b occ %0d",
						         rsp.status, rsp.out_handle, rsp.out_time, rsp.last,
						         rsp.occupancy);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.status !== want.status || rsp.out_handle !== want.out_handle ||
					    rsp.out_time !== want.out_time || rsp.last !== want.last ||
					    rsp.occupancy !== want.occupancy) begin
						n_err++;
						if (n_err <= 10) begin
							$write("response %0d mismatch: exp st %0d hnd %h time %h last %b",
							       n_rsp, want.status, want.out_handle, want.out_time,
							       want.last);
							$display(" occ %0d, got st %0d hnd %h time %h last %b occ %0d",
							         want.occupancy, rsp.status, rsp.out_handle,
							         rsp.out_time, rsp.last, rsp.occupancy);
						end
					end
				end
			end
			rsp_ready <= !((live_phase == IDLE_RECV || live_phase == IDLE_BOTH) &&
			               $urandom_range(99) < idle_pct(live_phase));
		end
	end

	initial begin : stimulus
		slot_t       recent [$];
		slot_t       s;
		idle_mode_e  ph;
		bit          hold;
		int          n_rand;
		int          roll;
		logic [31:0] t;
		logic [15:0] h;
		logic [31:0] id;

		// empty queue, field extremes, equal-time groups, duplicate handles
		queue_req(MODE_POP,    32'h0,         16'h0,    32'h0,         IDLE_NONE, 1'b0);
		queue_req(MODE_FIND,   32'h0,         16'h0,    32'h0,         IDLE_NONE, 1'b0);
		queue_req(MODE_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, IDLE_NONE, 1'b0);
		queue_req(MODE_PUSH,   32'h0,         16'h0,    32'h0,         IDLE_NONE, 1'b0);
		queue_req(MODE_PUSH,   32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, IDLE_NONE, 1'b0);
		queue_req(MODE_PUSH,   32'd5,         16'd1,    32'd7,         IDLE_NONE, 1'b0);
		queue_req(MODE_PUSH,   32'd5,         16'd2,    32'd7,         IDLE_NONE, 1'b0);
		queue_req(MODE_PUSH,   32'd5,         16'd1,    32'd9,         IDLE_NONE, 1'b0);
		queue_req(MODE_FIND,   32'h0,         16'h0,    32'd7,         IDLE_NONE, 1'b0);
		queue_req(MODE_FIND,   32'h0,         16'h0,    32'hFFFF_FFFF, IDLE_NONE, 1'b0);
		queue_req(MODE_FIND,   32'h0,         16'h0,    32'd12345,     IDLE_NONE, 1'b0);
		queue_req(MODE_REMOVE, 32'd5,         16'd1,    32'h0,         IDLE_NONE, 1'b0);
		queue_req(MODE_REMOVE, 32'd6,         16'd1,    32'h0,         IDLE_NONE, 1'b0);
		queue_req(MODE_POP,    32'h0,         16'h0,    32'h0,         IDLE_NONE, 1'b0);
		queue_req(MODE_POP,    32'h0,         16'h0,    32'h0,         IDLE_NONE, 1'b0);
		queue_req(MODE_PUSH,   32'd9,         16'd3,    32'd7,         IDLE_NONE, 1'b0);
		queue_req(MODE_PUSH,   32'd9,         16'd4,    32'd8,         IDLE_NONE, 1'b0);
		queue_req(MODE_PUSH,   32'd3,         16'd5,    32'd7,         IDLE_NONE, 1'b0);
		queue_req(MODE_FIND,   32'h0,         16'h0,    32'd7,         IDLE_NONE, 1'b0);
		queue_req(MODE_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 32'h0,         IDLE_NONE, 1'b0);
		queue_req(MODE_POP,    32'h0,         16'h0,    32'h0,         IDLE_NONE, 1'b0);
		queue_req(MODE_POP,    32'h0,         16'h0,    32'h0,         IDLE_NONE, 1'b0);
		queue_req(MODE_POP,    32'h0,         16'h0,    32'h0,         IDLE_NONE, 1'b0);
		queue_req(MODE_POP,    32'h0,         16'h0,    32'h0,         IDLE_NONE, 1'b0);

		n_rand = 0;
		while (n_rand < N_RANDOM) begin
			ph   = idle_mode_e'((n_rand / 45) % 4);
			hold = (n_rand % 70 == 69);
			if (n_rand == 150) begin
				// enough pushes to reach full from any occupancy, then some dropped
				repeat (70)
					queue_req(MODE_PUSH, pick_time(), 16'($urandom), 32'($urandom), ph, 1'b0);
				n_rand += 70;
				continue;
			end
			roll = $urandom_range(99);
			if (roll < 40) begin
				s.s_time    = pick_time();
				s.s_handle  = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(7));
				s.s_request = $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(15));
				queue_req(MODE_PUSH, s.s_time, s.s_handle, s.s_request, ph, hold);
				recent.insert(recent.size(), s);
				if (recent.size() > 32)
					void'(recent.pop_front());
			end else if (roll < 60) begin
				queue_req(MODE_POP, 32'($urandom), 16'($urandom), 32'($urandom), ph, hold);
			end else if (roll < 80) begin
				id = 32'($urandom);
				if (recent.size() != 0 && $urandom_range(99) < 70)
					id = recent[$urandom_range(recent.size() - 1)].s_request;
				queue_req(MODE_FIND, 32'($urandom), 16'($urandom), id, ph, hold);
			end else begin
				t    = pick_time();
				h    = 16'($urandom);
				roll = $urandom_range(99);
				if (recent.size() != 0 && roll < 85) begin
					s = recent[$urandom_range(recent.size() - 1)];
					h = s.s_handle;
					// right handle, with the exact time or a near miss with the time off by one
					t = (roll < 70) ? s.s_time : s.s_time + 32'd1;
				end
				queue_req(MODE_REMOVE, t, h, 32'($urandom), ph, hold);
			end
			n_rand++;
		end
		n_total = req_backlog.size();

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (n_accepted != n_total || pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d requests: %0d push (%0d dropped), %0d pop, %0d find, %0d remove",
		         n_accepted, n_push, n_full, n_pop, n_find, n_remove);
		$display("Checked %0d responses, peak occupancy %0d, %0d mismatches",
		         n_rsp, peak_fill, n_err);
		if (n_err == 0 && pending_rsp.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#(8 * 1_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
src/toeq_pkg.sv
src/toeq_ram.sv
src/toeq_ctrl.sv
src/toeq_dpath.sv
src/time_ordered_event_queue_core.sv
dv/tb_time_ordered_event_queue_core.sv
